// ===== rtl/estb_pkg.sv =====
// ----------------------------------------------------------------------------
// estb_pkg: shared types and constants of the entity slot table
// Command codes, payload structs, slot entry layout and the constant
// per-type table (flag byte and start band).
// ----------------------------------------------------------------------------
package estb_pkg;

	localparam int unsigned SlotCountDef = 256;
	localparam int unsigned TypeCount    = 122;
	localparam int unsigned TableLen     = 122;
	localparam int unsigned BandDiv      = 10;
	localparam logic [7:0]  ScrollFlag   = 8'h10;
	localparam logic [6:0]  ReplaceType  = 7'd1;

	typedef enum logic [2:0] {
		CMD_CREATE  = 3'd0,
		CMD_COUNT   = 3'd1,
		CMD_CLEAR   = 3'd2,
		CMD_REPLACE = 3'd3,
		CMD_RESET   = 3'd4
	} cmd_t;

	typedef enum logic [0:0] {
		CFG_SCROLL_X = 1'b0,
		CFG_SCROLL_Y = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_WIPE,
		ST_IDLE,
		ST_SCAN,
		ST_FIND,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [2:0]         command;
		logic [6:0]         entity_type;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic [15:0]        subtype;
	} item_t;

	typedef struct packed {
		logic [7:0]  slot_index;
		logic        created;
		logic [8:0]  match_count;
		logic [31:0] serial_number;
	} result_t;

	typedef struct packed {
		logic        valid;
		logic [6:0]  etype;
		logic        scrolled;
		logic [31:0] x;
		logic [31:0] y;
	} ent_t;

	localparam logic [7:0] TypeFlag [TableLen] = '{
		8'd16, 8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd2,  8'd67, 8'd67,
		8'd0,  8'd67, 8'd10, 8'd34, 8'd34, 8'd0,  8'd0,  8'd0,  8'd2,  8'd0,
		8'd67, 8'd67, 8'd0,  8'd67, 8'd0,  8'd0,  8'd67, 8'd67, 8'd67, 8'd0,
		8'd67, 8'd67, 8'd0,  8'd10, 8'd10, 8'd67, 8'd0,  8'd0,  8'd0,  8'd16,
		8'd16, 8'd16, 8'd16, 8'd67, 8'd16, 8'd2,  8'd0,  8'd0,  8'd16, 8'd16,
		8'd0,  8'd16, 8'd16, 8'd16, 8'd16, 8'd16, 8'd0,  8'd16, 8'd16, 8'd0,
		8'd16, 8'd16, 8'd16, 8'd0,  8'd0,  8'd16, 8'd67, 8'd16, 8'd16, 8'd16,
		8'd67, 8'd0,  8'd67, 8'd0,  8'd16, 8'd67, 8'd0,  8'd0,  8'd0,  8'd0,
		8'd0,  8'd16, 8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd67, 8'd10,
		8'd67, 8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd16, 8'd34, 8'd16,
		8'd16, 8'd16, 8'd0,  8'd34, 8'd34, 8'd34, 8'd0,  8'd0,  8'd0,  8'd0,
		8'd0,  8'd2,  8'd0,  8'd0,  8'd34, 8'd0,  8'd0,  8'd0,  8'd0,  8'd0,
		8'd0,  8'd16
	};

	localparam logic [3:0] TypeBand [TableLen] = '{
		4'd3, 4'd8, 4'd3, 4'd2, 4'd5, 4'd6, 4'd0, 4'd8, 4'd5, 4'd5,
		4'd9, 4'd4, 4'd4, 4'd8, 4'd8, 4'd4, 4'd4, 4'd4, 4'd8, 4'd0,
		4'd4, 4'd4, 4'd0, 4'd5, 4'd6, 4'd6, 4'd5, 4'd4, 4'd4, 4'd8,
		4'd4, 4'd6, 4'd4, 4'd4, 4'd4, 4'd6, 4'd4, 4'd0, 4'd0, 4'd4,
		4'd3, 4'd3, 4'd4, 4'd5, 4'd5, 4'd8, 4'd0, 4'd4, 4'd3, 4'd3,
		4'd9, 4'd4, 4'd4, 4'd4, 4'd5, 4'd3, 4'd9, 4'd4, 4'd3, 4'd6,
		4'd3, 4'd3, 4'd4, 4'd8, 4'd6, 4'd3, 4'd5, 4'd3, 4'd3, 4'd3,
		4'd5, 4'd4, 4'd6, 4'd4, 4'd3, 4'd4, 4'd7, 4'd8, 4'd4, 4'd6,
		4'd5, 4'd5, 4'd8, 4'd8, 4'd6, 4'd3, 4'd2, 4'd0, 4'd4, 4'd4,
		4'd5, 4'd2, 4'd0, 4'd0, 4'd4, 4'd3, 4'd2, 4'd3, 4'd8, 4'd3,
		4'd4, 4'd4, 4'd0, 4'd8, 4'd8, 4'd8, 4'd3, 4'd0, 4'd5, 4'd4,
		4'd6, 4'd7, 4'd6, 4'd6, 4'd7, 4'd8, 4'd0, 4'd0, 4'd0, 4'd3,
		4'd6, 4'd3
	};

	function automatic logic [3:0] type_band(input logic [6:0] t);
		if ({25'd0, t} < TableLen)
			return TypeBand[t];
		return 4'd0;
	endfunction

	function automatic logic type_scroll(input logic [6:0] t);
		if ({25'd0, t} < TableLen)
			return (TypeFlag[t] & ScrollFlag) != 8'd0;
		return 1'b0;
	endfunction

endpackage

// ===== rtl/typed_entity_slot_table_top.sv =====
// ----------------------------------------------------------------------------
// typed_entity_slot_table_top: typed entity slot table
// Slot store in one RAM, walked one slot per cycle by a small sequencer
// for create, count, clear, clear-and-replace and table reset.
//
//   channel  handshake           payload
//   cmd      cmd_valid/cmd_stall  cmd_data  (estb_pkg::item_t)
//   rsp      rsp_valid/rsp_stall  rsp_data  (estb_pkg::result_t)
//   cfg      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Count/clear walk every slot, plus for each replacement the slots walked
// from the type 1 start slot. Create walks from the type's start slot.
// Reset command wipes every slot. One RAM read per cycle sets the pace.
// After arst_n the RAM is wiped slot by slot; cmd is stalled then.
// A waiting result in the rsp register does not block the next transfer.
// ----------------------------------------------------------------------------
module typed_entity_slot_table_top #(
	parameter int unsigned SLOT_COUNT = estb_pkg::SlotCountDef
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  estb_pkg::item_t   cmd_data,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output estb_pkg::result_t rsp_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [0:0]        cfg_index,
	input  logic [31:0]       cfg_data
);

	import estb_pkg::*;

	localparam int unsigned IW = $clog2(SLOT_COUNT);
	localparam int unsigned EW = $bits(ent_t);

	state_t state_q, state_d;
	cmd_t   cmd_q;

	logic [IW-1:0] pos_q, pos_d, sav_q;
	logic          nest_q, wipe_res_q;
	logic [6:0]    type_q, ctype_q;
	logic [31:0]   cx_q, cy_q;
	logic          scr_q;
	logic [8:0]    cnt_q;
	logic [31:0]   ctr_q;
	logic [31:0]   sx_q, sy_q;
	logic [7:0]    slot_q;
	logic          created_q;
	logic [31:0]   serial_q;
	logic          hz_q;
	ent_t          byp_q;
	logic          out_valid_q;
	result_t       out_q;

	logic          we;
	logic [IW-1:0] waddr, raddr;
	ent_t          wdata, ent;
	logic [EW-1:0] rdata;

	logic          acc, last, sav_last, match, free, type_ok, take;
	logic [31:0]   alu_bx, alu_by, alu_x, alu_y;
	logic          alu_apply, alu_sub;

	function automatic logic [IW-1:0] start_slot(input logic [3:0] band);
		case (band)
			4'd1:    return IW'((1 * SLOT_COUNT) / BandDiv);
			4'd2:    return IW'((2 * SLOT_COUNT) / BandDiv);
			4'd3:    return IW'((3 * SLOT_COUNT) / BandDiv);
			4'd4:    return IW'((4 * SLOT_COUNT) / BandDiv);
			4'd5:    return IW'((5 * SLOT_COUNT) / BandDiv);
			4'd6:    return IW'((6 * SLOT_COUNT) / BandDiv);
			4'd7:    return IW'((7 * SLOT_COUNT) / BandDiv);
			4'd8:    return IW'((8 * SLOT_COUNT) / BandDiv);
			4'd9:    return IW'((9 * SLOT_COUNT) / BandDiv);
			default: return '0;
		endcase
	endfunction

	estb_ram #(
		.WIDTH(EW),
		.DEPTH(SLOT_COUNT)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	estb_pos_alu u_alu (
		.base_x  (alu_bx),
		.base_y  (alu_by),
		.off_x   (sx_q),
		.off_y   (sy_q),
		.apply   (alu_apply),
		.subtract(alu_sub),
		.res_x   (alu_x),
		.res_y   (alu_y)
	);

	assign cmd_stall = state_q != ST_IDLE;
	assign acc       = cmd_valid && !cmd_stall;
	assign cfg_ready = 1'b1;
	assign rsp_valid = out_valid_q;
	assign rsp_data  = out_q;

	// same-cycle write/read of one slot: forward the written entry
	assign ent      = hz_q ? byp_q : ent_t'(rdata);
	assign last     = pos_q == IW'(SLOT_COUNT - 1);
	assign sav_last = sav_q == IW'(SLOT_COUNT - 1);
	assign match    = ent.valid && (ent.etype == type_q);
	assign free     = !ent.valid;
	assign type_ok  = {1'b0, cmd_data.entity_type} < 8'(TypeCount);
	assign take     = !out_valid_q || !rsp_stall;

	always_comb begin
		if (state_q == ST_SCAN) begin
			alu_bx    = ent.x;
			alu_by    = ent.y;
			alu_apply = ent.scrolled;
			alu_sub   = 1'b1;
		end else begin
			alu_bx    = cx_q;
			alu_by    = cy_q;
			alu_apply = scr_q;
			alu_sub   = 1'b0;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_WIPE: begin
				if (last)
					state_d = wipe_res_q ? ST_DONE : ST_IDLE;
			end
			ST_IDLE: begin
				if (acc) begin
					case (cmd_t'(cmd_data.command))
						CMD_CREATE:  state_d = type_ok ? ST_FIND : ST_DONE;
						CMD_COUNT:   state_d = ST_SCAN;
						CMD_CLEAR:   state_d = ST_SCAN;
						CMD_REPLACE: state_d = ST_SCAN;
						CMD_RESET:   state_d = ST_WIPE;
						default:     state_d = ST_DONE;
					endcase
				end
			end
			ST_SCAN: begin
				if (match && cmd_q == CMD_REPLACE)
					state_d = ST_FIND;
				else if (last)
					state_d = ST_DONE;
			end
			ST_FIND: begin
				if (free || last) begin
					if (nest_q && !sav_last)
						state_d = ST_SCAN;
					else
						state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (take)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// RAM access and walk position
	always_comb begin
		pos_d = pos_q;
		we    = 1'b0;
		waddr = pos_q;
		wdata = ent;
		case (state_q)
			ST_WIPE: begin
				we    = 1'b1;
				wdata = '0;
				pos_d = pos_q + 1'b1;
			end
			ST_IDLE: begin
				if (cmd_t'(cmd_data.command) == CMD_CREATE)
					pos_d = start_slot(type_band(cmd_data.entity_type));
				else
					pos_d = '0;
			end
			ST_SCAN: begin
				pos_d = pos_q + 1'b1;
				if (match && (cmd_q == CMD_CLEAR || cmd_q == CMD_REPLACE)) begin
					we          = 1'b1;
					wdata.valid = 1'b0;
				end
				if (match && cmd_q == CMD_REPLACE)
					pos_d = start_slot(type_band(ReplaceType));
			end
			ST_FIND: begin
				if (free) begin
					we             = 1'b1;
					wdata.valid    = 1'b1;
					wdata.etype    = ctype_q;
					wdata.scrolled = scr_q;
					wdata.x        = alu_x;
					wdata.y        = alu_y;
				end
				if (free || last)
					pos_d = nest_q ? sav_q + 1'b1 : pos_q;
				else
					pos_d = pos_q + 1'b1;
			end
			default: pos_d = pos_q;
		endcase
	end

	assign raddr = pos_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_WIPE;
			pos_q       <= '0;
			nest_q      <= 1'b0;
			wipe_res_q  <= 1'b0;
			ctr_q       <= '0;
			sx_q        <= '0;
			sy_q        <= '0;
			hz_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pos_q   <= pos_d;
			hz_q    <= we && (waddr == raddr);

			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_SCROLL_X: sx_q <= cfg_data;
					CFG_SCROLL_Y: sy_q <= cfg_data;
					default:      sx_q <= sx_q;
				endcase
			end

			if (acc) begin
				nest_q     <= 1'b0;
				wipe_res_q <= cmd_t'(cmd_data.command) == CMD_RESET;
				if (cmd_t'(cmd_data.command) == CMD_RESET)
					ctr_q <= '0;
			end

			if (state_q == ST_SCAN && match && cmd_q == CMD_REPLACE)
				nest_q <= 1'b1;

			if (state_q == ST_FIND) begin
				if (free)
					ctr_q <= ctr_q + 32'd1;
				if (free || last)
					nest_q <= 1'b0;
			end

			if (state_q == ST_DONE && take)
				out_valid_q <= 1'b1;
			else if (!rsp_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		byp_q <= wdata;

		if (acc) begin
			cmd_q     <= cmd_t'(cmd_data.command);
			type_q    <= cmd_data.entity_type;
			ctype_q   <= cmd_data.entity_type;
			scr_q     <= type_scroll(cmd_data.entity_type);
			cx_q      <= cmd_data.pos_x;
			cy_q      <= cmd_data.pos_y;
			cnt_q     <= '0;
			slot_q    <= '0;
			created_q <= 1'b0;
			serial_q  <= '0;
		end

		if (state_q == ST_SCAN) begin
			if (match && cnt_q != 9'h1FF)
				cnt_q <= cnt_q + 9'd1;
			if (match && cmd_q == CMD_REPLACE) begin
				sav_q   <= pos_q;
				ctype_q <= ReplaceType;
				scr_q   <= type_scroll(ReplaceType);
				cx_q    <= alu_x;
				cy_q    <= alu_y;
			end
		end

		if (state_q == ST_FIND && free && !nest_q) begin
			created_q <= 1'b1;
			slot_q    <= 8'(pos_q);
			serial_q  <= ctr_q;
		end

		if (state_q == ST_DONE && take) begin
			out_q.slot_index    <= slot_q;
			out_q.created       <= created_q;
			out_q.match_count   <= cnt_q;
			out_q.serial_number <= serial_q;
		end
	end

endmodule

// ===== rtl/estb_ram.sv =====
// ----------------------------------------------------------------------------
// estb_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module estb_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/estb_pos_alu.sv =====
// ----------------------------------------------------------------------------
// estb_pos_alu: shared position adder
// Adds or removes the scroll offset on an x/y pair; passes the pair
// through unchanged when the offset does not apply.
// ----------------------------------------------------------------------------
module estb_pos_alu (
	input  logic [31:0] base_x,
	input  logic [31:0] base_y,
	input  logic [31:0] off_x,
	input  logic [31:0] off_y,
	input  logic        apply,
	input  logic        subtract,
	output logic [31:0] res_x,
	output logic [31:0] res_y
);

	logic [31:0] opx;
	logic [31:0] opy;

	always_comb begin
		opx = apply ? off_x : 32'd0;
		opy = apply ? off_y : 32'd0;
		if (subtract) begin
			res_x = base_x - opx;
			res_y = base_y - opy;
		end else begin
			res_x = base_x + opx;
			res_y = base_y + opy;
		end
	end

endmodule

// ===== verif/tb_typed_entity_slot_table_top.sv =====
// ----------------------------------------------------------------------------
// tb_typed_entity_slot_table_top: self-checking bench for the entity slot table
// A directed table of commands, followed by random phases under different
// scroll settings. Each accepted command runs through a local slot-table
// predictor, and every response is compared field by field, in order.
// Both channels idle and stall at random, and one long receiver hold-off
// backs the block up into its command channel.
// ----------------------------------------------------------------------------
module tb_typed_entity_slot_table_top;
	import estb_pkg::*;

	localparam int          SLOTS       = 256;
	localparam int          TYPE_ROWS   = 122;
	localparam int          BAND_DIV    = 10;
	localparam logic [7:0]  SCROLL_BIT  = 8'h10;
	localparam logic [6:0]  REPL_TYPE   = 7'd1;
	localparam logic [2:0]  CMD_RSVD5   = 3'd5;
	localparam logic [2:0]  CMD_RSVD6   = 3'd6;
	localparam logic [2:0]  CMD_RSVD7   = 3'd7;
	localparam int          HOLD_CYCLES = 3000;
	localparam int          TAIL_CYCLES = 300;

	// per type: flag byte and start band
	localparam logic [7:0] KIND_FLAG [TYPE_ROWS] = '{
		16, 0,  0,  0,  0,  0,  0,  2,  67, 67,
		0,  67, 10, 34, 34, 0,  0,  0,  2,  0,
		67, 67, 0,  67, 0,  0,  67, 67, 67, 0,
		67, 67, 0,  10, 10, 67, 0,  0,  0,  16,
		16, 16, 16, 67, 16, 2,  0,  0,  16, 16,
		0,  16, 16, 16, 16, 16, 0,  16, 16, 0,
		16, 16, 16, 0,  0,  16, 67, 16, 16, 16,
		67, 0,  67, 0,  16, 67, 0,  0,  0,  0,
		0,  16, 0,  0,  0,  0,  0,  0,  67, 10,
		67, 0,  0,  0,  0,  0,  0,  16, 34, 16,
		16, 16, 0,  34, 34, 34, 0,  0,  0,  0,
		0,  2,  0,  0,  34, 0,  0,  0,  0,  0,
		0,  16
	};

	localparam logic [3:0] KIND_BAND [TYPE_ROWS] = '{
		3, 8, 3, 2, 5, 6, 0, 8, 5, 5,
		9, 4, 4, 8, 8, 4, 4, 4, 8, 0,
		4, 4, 0, 5, 6, 6, 5, 4, 4, 8,
		4, 6, 4, 4, 4, 6, 4, 0, 0, 4,
		3, 3, 4, 5, 5, 8, 0, 4, 3, 3,
		9, 4, 4, 4, 5, 3, 9, 4, 3, 6,
		3, 3, 4, 8, 6, 3, 5, 3, 3, 3,
		5, 4, 6, 4, 3, 4, 7, 8, 4, 6,
		5, 5, 8, 8, 6, 3, 2, 0, 4, 4,
		5, 2, 0, 0, 4, 3, 2, 3, 8, 3,
		4, 4, 0, 8, 8, 8, 3, 0, 5, 4,
		6, 7, 6, 6, 7, 8, 0, 0, 0, 3,
		6, 3
	};

	typedef struct packed {
		logic [2:0]  op;
		logic [6:0]  etype;
		logic [31:0] px;
		logic [31:0] py;
		logic [15:0] sub;
		logic        fixed;
		logic [7:0]  slot;
		logic        made;
		logic [8:0]  cnt;
		logic [31:0] serial;
	} step_row_t;

	localparam int DIRECTED_LEN = 22;

	// fixed = 1: response typed in; fixed = 0: response from the predictor
	localparam step_row_t DIRECTED [DIRECTED_LEN] = '{
		'{CMD_COUNT,   7'd0,   32'h0,        32'h0,        16'h0,    1'b1, 8'd0,   1'b0, 9'd0, 32'd0},
		'{CMD_CREATE,  7'd0,   32'h7FFFFFFF, 32'h80000000, 16'hFFFF, 1'b1, 8'd76,  1'b1, 9'd0, 32'd0},
		'{CMD_CREATE,  7'd6,   32'h80000000, 32'h7FFFFFFF, 16'h0,    1'b1, 8'd0,   1'b1, 9'd0, 32'd1},
		'{CMD_CREATE,  7'd10,  32'hFFFFFFFF, 32'h0,        16'h5A5A, 1'b1, 8'd230, 1'b1, 9'd0, 32'd2},
		'{CMD_CREATE,  7'd121, 32'h12345678, 32'h9ABCDEF0, 16'hA5A5, 1'b1, 8'd77,  1'b1, 9'd0, 32'd3},
		'{CMD_CREATE,  7'd122, 32'h1,        32'h1,        16'h1,    1'b1, 8'd0,   1'b0, 9'd0, 32'd0},
		'{CMD_CREATE,  7'd127, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 1'b1, 8'd0,   1'b0, 9'd0, 32'd0},
		'{CMD_COUNT,   7'd0,   32'h0,        32'h0,        16'h0,    1'b1, 8'd0,   1'b0, 9'd1, 32'd0},
		'{CMD_RSVD5,   7'd0,   32'h0,        32'h0,        16'h0,    1'b1, 8'd0,   1'b0, 9'd0, 32'd0},
		'{CMD_RSVD6,   7'd127, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 1'b1, 8'd0,   1'b0, 9'd0, 32'd0},
		'{CMD_RSVD7,   7'd0,   32'h0,        32'h0,        16'h0,    1'b1, 8'd0,   1'b0, 9'd0, 32'd0},
		'{CMD_REPLACE, 7'd0,   32'h0,        32'h0,        16'h0,    1'b1, 8'd0,   1'b0, 9'd1, 32'd0},
		'{CMD_COUNT,   7'd1,   32'h0,        32'h0,        16'h0,    1'b1, 8'd0,   1'b0, 9'd1, 32'd0},
		'{CMD_CREATE,  7'd1,   32'h55555555, 32'hAAAAAAAA, 16'h0,    1'b1, 8'd205, 1'b1, 9'd0, 32'd5},
		'{CMD_REPLACE, 7'd1,   32'h0,        32'h0,        16'h0,    1'b0, 8'd0,   1'b0, 9'd0, 32'd0},
		'{CMD_CLEAR,   7'd1,   32'h0,        32'h0,        16'h0,    1'b0, 8'd0,   1'b0, 9'd0, 32'd0},
		'{CMD_CLEAR,   7'd6,   32'h0,        32'h0,        16'h0,    1'b1, 8'd0,   1'b0, 9'd1, 32'd0},
		'{CMD_COUNT,   7'd10,  32'h0,        32'h0,        16'h0,    1'b1, 8'd0,   1'b0, 9'd1, 32'd0},
		'{CMD_RESET,   7'd0,   32'h0,        32'h0,        16'h0,    1'b1, 8'd0,   1'b0, 9'd0, 32'd0},
		'{CMD_CREATE,  7'd6,   32'h0,        32'h0,        16'h0,    1'b1, 8'd0,   1'b1, 9'd0, 32'd0},
		'{CMD_COUNT,   7'd127, 32'h0,        32'h0,        16'h0,    1'b1, 8'd0,   1'b0, 9'd0, 32'd0},
		'{CMD_COUNT,   7'd6,   32'h0,        32'h0,        16'h0,    1'b1, 8'd0,   1'b0, 9'd1, 32'd0}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cmd_valid = 1'b0;
	logic        cmd_stall;
	item_t       cmd_data = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	result_t     rsp_data;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [0:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	// predicted slot table
	logic        slot_live [SLOTS];
	logic [6:0]  slot_kind [SLOTS];
	logic [31:0] slot_px [SLOTS];
	logic [31:0] slot_py [SLOTS];
	logic        slot_scr [SLOTS];
	logic [31:0] serial_next;
	logic [31:0] scroll_x_q = '0;
	logic [31:0] scroll_y_q = '0;

	result_t     pending_results [$];
	result_t     oldest;
	int          errors = 0;

	int          hold_token = 0;
	int          hold_seen = 0;
	int          stall_left = 0;
	int          rx_mode_left = 0;
	int          rx_pick;
	bit          rx_calm = 1'b0;
	bit          tx_calm = 1'b0;

	typed_entity_slot_table_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_data  (cmd_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	function automatic void wipe_table();
		for (int i = 0; i < SLOTS; i++) begin
			slot_live[i] = 1'b0;
			slot_kind[i] = '0;
			slot_px[i]   = '0;
			slot_py[i]   = '0;
			slot_scr[i]  = 1'b0;
		end
		serial_next = '0;
	endfunction

	// returns the slot filled, or -1
	function automatic int place_entity(logic [6:0] t, logic [31:0] x, logic [31:0] y);
		int s;
		logic scr;
		if (int'(t) >= TYPE_ROWS)
			return -1;
		scr = (KIND_FLAG[t] & SCROLL_BIT) != 8'd0;
		s = (int'(KIND_BAND[t]) * SLOTS) / BAND_DIV;
		while (s < SLOTS && slot_live[s])
			s++;
		if (s >= SLOTS)
			return -1;
		slot_live[s] = 1'b1;
		slot_kind[s] = t;
		slot_px[s]   = scr ? x + scroll_x_q : x;
		slot_py[s]   = scr ? y + scroll_y_q : y;
		slot_scr[s]  = scr;
		serial_next  = serial_next + 32'd1;
		return s;
	endfunction

	function automatic result_t apply_command(item_t it);
		result_t r;
		int s;
		int unsigned hits;
		logic [31:0] sn, x, y;
		r = '0;
		hits = 0;
		case (it.command)
			CMD_CREATE: begin
				sn = serial_next;
				s = place_entity(it.entity_type, it.pos_x, it.pos_y);
				if (s >= 0) begin
					r.slot_index    = s[7:0];
					r.created       = 1'b1;
					r.serial_number = sn;
				end
			end
			CMD_COUNT, CMD_CLEAR, CMD_REPLACE: begin
				for (int i = 0; i < SLOTS; i++) begin
					if (slot_live[i] && slot_kind[i] == it.entity_type) begin
						hits++;
						if (it.command != CMD_COUNT) begin
							slot_live[i] = 1'b0;
							if (it.command == CMD_REPLACE) begin
								x = slot_scr[i] ? slot_px[i] - scroll_x_q : slot_px[i];
								y = slot_scr[i] ? slot_py[i] - scroll_y_q : slot_py[i];
								s = place_entity(REPL_TYPE, x, y);
							end
						end
					end
				end
				r.match_count = (hits > 511) ? 9'd511 : hits[8:0];
			end
			CMD_RESET: wipe_table();
			default: ;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] rand_pos();
		case ($urandom_range(0, 9))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return 32'hFFFFFFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic int pick_gap();
		int r;
		if (tx_calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	task automatic send_item(input item_t it, input bit fixed, input result_t want);
		int gap;
		result_t predicted;
		gap = pick_gap();
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_data  <= it;
		do @(posedge clk); while (cmd_stall);
		predicted = apply_command(it);
		pending_results.push_back(fixed ? want : predicted);
	endtask

	task automatic wait_drained();
		int guard;
		guard = 0;
		cmd_valid <= 1'b0;
		while (pending_results.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
	endtask

	task automatic write_scroll(input logic [31:0] x, input logic [31:0] y);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_SCROLL_X;
		cfg_data  <= x;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= CFG_SCROLL_Y;
		cfg_data  <= y;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		scroll_x_q = x;
		scroll_y_q = y;
	endtask

	// response checker
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_results.size() == 0) begin
				$error("unexpected response transfer: %p", rsp_data);
				errors++;
			end else begin
				oldest = pending_results.pop_front();
				if (rsp_data.slot_index !== oldest.slot_index) begin
					$error("slot_index: expected %0d, got %0d",
						oldest.slot_index, rsp_data.slot_index);
					errors++;
				end
				if (rsp_data.created !== oldest.created) begin
					$error("created: expected %0d, got %0d", oldest.created, rsp_data.created);
					errors++;
				end
				if (rsp_data.match_count !== oldest.match_count) begin
					$error("match_count: expected %0d, got %0d",
						oldest.match_count, rsp_data.match_count);
					errors++;
				end
				if (rsp_data.serial_number !== oldest.serial_number) begin
					$error("serial_number: expected %0d, got %0d",
						oldest.serial_number, rsp_data.serial_number);
					errors++;
				end
			end
		end
	end

	// receiver back-pressure
	always @(posedge clk) begin
		if (rx_mode_left == 0) begin
			rx_calm = ($urandom_range(0, 2) == 0);
			rx_mode_left = 500;
		end
		rx_mode_left--;
		if (hold_token != hold_seen) begin
			hold_seen = hold_token;
			stall_left = HOLD_CYCLES;
		end
		if (stall_left == 0 && !rx_calm) begin
			rx_pick = $urandom_range(0, 99);
			if (rx_pick >= 97)
				stall_left = $urandom_range(20, 80);
			else if (rx_pick >= 85)
				stall_left = $urandom_range(1, 4);
		end
		rsp_stall <= (stall_left != 0);
		if (stall_left != 0)
			stall_left--;
	end

	initial begin
		#100_000_000;
		$display("FAIL typed_entity_slot_table_top");
		$finish;
	end

	initial begin
		item_t       it;
		result_t     want;
		step_row_t   row;
		int          r, s;
		logic [31:0] sx, sy;

		wipe_table();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_scroll(32'h7FFFFFFF, 32'h80000000);
		for (int k = 0; k < DIRECTED_LEN; k++) begin
			row = DIRECTED[k];
			it.command     = row.op;
			it.entity_type = row.etype;
			it.pos_x       = row.px;
			it.pos_y       = row.py;
			it.subtype     = row.sub;
			want.slot_index    = row.slot;
			want.created       = row.made;
			want.match_count   = row.cnt;
			want.serial_number = row.serial;
			send_item(it, row.fixed, want);
		end

		for (int ph = 1; ph <= 4; ph++) begin
			wait_drained();
			case (ph)
				1: begin sx = 32'h80000000; sy = 32'h7FFFFFFF; end
				2: begin sx = 32'h0;        sy = 32'hFFFFFFFF; end
				3: begin sx = $urandom;     sy = $urandom;     end
				default: begin sx = 32'hFFFFFFFF; sy = 32'h0; end
			endcase
			write_scroll(sx, sy);
			if (ph == 2)
				hold_token++;
			for (int n = 0; n < 120; n++) begin
				if (n % 40 == 0)
					tx_calm = ($urandom_range(0, 3) == 0);
				r = $urandom_range(0, 99);
				if (ph == 1)
					it.command = (r < 85) ? CMD_CREATE : (r < 95) ? CMD_COUNT :
						(r < 98) ? CMD_CLEAR : CMD_REPLACE;
				else if (r < 50) it.command = CMD_CREATE;
				else if (r < 64) it.command = CMD_COUNT;
				else if (r < 74) it.command = CMD_CLEAR;
				else if (r < 86) it.command = CMD_REPLACE;
				else if (r < 90) it.command = CMD_RESET;
				else if (r < 93) it.command = CMD_RSVD5;
				else if (r < 96) it.command = CMD_RSVD6;
				else it.command = CMD_RSVD7;

				// counts and clears mostly target a type that is in the table
				s = $urandom_range(0, SLOTS - 1);
				if (it.command == CMD_CREATE)
					it.entity_type = ($urandom_range(0, 19) == 0) ?
						$urandom_range(TYPE_ROWS, 127) : $urandom_range(0, TYPE_ROWS - 1);
				else if ($urandom_range(0, 9) < 7 && slot_live[s])
					it.entity_type = slot_kind[s];
				else
					it.entity_type = $urandom_range(0, 127);
				it.pos_x   = rand_pos();
				it.pos_y   = rand_pos();
				it.subtype = $urandom_range(0, 65535);
				send_item(it, 1'b0, '0);
			end
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d responses never arrived", pending_results.size());
			errors++;
		end
		if (errors == 0)
			$display("PASS typed_entity_slot_table_top");
		else
			$display("FAIL typed_entity_slot_table_top");
		$finish;
	end

endmodule
